// File: rtl/core/int8_fully_connected_mac_top_defines.svh
// Assertion macros shared by the int8 fully connected MAC core.
// No dependencies; included by the top level only.
`ifndef INT8_FULLY_CONNECTED_MAC_TOP_DEFINES_SVH
`define INT8_FULLY_CONNECTED_MAC_TOP_DEFINES_SVH

// same-cycle implication
`define FCM_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define FCM_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/fcm_pkg.sv
// Shared types and constants for the int8 fully connected MAC core.
// No dependencies.
`default_nettype none

package fcm_pkg;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_ZP  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_ZP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACT_MIN   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACT_MAX   = 2'd3;

  localparam logic signed [7:0]  INT8_MIN  = -8'sd128;
  localparam logic signed [7:0]  INT8_MAX  = 8'sd127;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;

  // rounding offsets of the doubling high multiply
  localparam logic signed [63:0] NUDGE_POS = 64'sd1073741824;
  localparam logic signed [63:0] NUDGE_NEG = -64'sd1073741823;

  // one finished row handed from front to back
  typedef struct packed {
    logic signed [31:0] acc;
    logic signed [31:0] bias;
    logic        [30:0] multiplier;
    logic signed [5:0]  shift;
    logic               last_channel;
  } row_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
  } bk_status_t;

  typedef struct packed {
    logic signed [7:0] output_zero_point;
    logic signed [7:0] act_min;
    logic signed [7:0] act_max;
  } clamp_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LSH,
    BK_MUL,
    BK_RND,
    BK_DIV,
    BK_RSH,
    BK_OFS,
    BK_CLAMP
  } bk_state_t;

endpackage

`default_nettype wire

// File: rtl/core/fcm_channels.sv
// Valid/ready channel interfaces for the int8 fully connected MAC core.
// No dependencies.
`default_nettype none

interface fcm_in_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  activation;
  logic signed [7:0]  weight;
  logic               last_in_row;
  logic signed [31:0] bias;
  logic        [30:0] multiplier;
  logic signed [5:0]  shift;
  logic               last_channel;

  modport source (output valid, activation, weight, last_in_row, bias, multiplier,
                  shift, last_channel, input ready);
  modport sink   (input valid, activation, weight, last_in_row, bias, multiplier,
                  shift, last_channel, output ready);
endinterface

interface fcm_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] result_value;
  logic              last_output;

  modport source (output valid, result_value, last_output, input ready);
  modport sink   (input valid, result_value, last_output, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fcm_front.sv
// Front end: accepts requests, one MAC per cycle unless queue is full, hands rows on.
// Depends on fcm_pkg and fcm_in_if.
`default_nettype none

module fcm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic signed [7:0] input_zero_point,
  fcm_in_if.sink            in_ch,
  input  fcm_pkg::q_status_t q_stat,
  output logic              push,
  output fcm_pkg::row_job_t push_job
);
  import fcm_pkg::*;

  logic signed [31:0] accumulator;
  logic signed [8:0]  diff;
  logic signed [16:0] prod;
  logic signed [31:0] acc_sum;
  logic               accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign diff    = {in_ch.activation[7], in_ch.activation}
                 - {input_zero_point[7], input_zero_point};
  assign prod    = diff * in_ch.weight;
  assign acc_sum = accumulator + 32'(prod);

  assign push = accept && in_ch.last_in_row;

  always_comb begin
    push_job.acc          = acc_sum;
    push_job.bias         = in_ch.bias;
    push_job.multiplier   = in_ch.multiplier;
    push_job.shift        = in_ch.shift;
    push_job.last_channel = in_ch.last_channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
    end else if (accept) begin
      accumulator <= in_ch.last_in_row ? 32'sd0 : acc_sum;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fcm_queue.sv
// Small FIFO of finished rows between front and back end.
// Depends on fcm_pkg.
`default_nettype none

module fcm_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fcm_pkg::row_job_t  push_job,
  input  logic               pop,
  output fcm_pkg::row_job_t  head,
  output fcm_pkg::q_status_t q_stat
);
  import fcm_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  row_job_t           entries [DEPTH];
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fcm_back.sv
// Back end: requantizes one row over several steps and holds the result.
// Depends on fcm_pkg and fcm_out_if.
`default_nettype none

module fcm_back (
  input  logic                clk,
  input  logic                rst,
  input  fcm_pkg::clamp_cfg_t cfg,
  input  fcm_pkg::row_job_t   head,
  input  fcm_pkg::q_status_t  q_stat,
  output logic                pop,
  output fcm_pkg::bk_status_t bk_stat,
  fcm_out_if.source           out_ch
);
  import fcm_pkg::*;

  bk_state_t state;
  bk_state_t state_next;

  logic signed [31:0] x;
  logic        [30:0] mult;
  logic signed [5:0]  shamt;
  logic               last_ch;
  logic signed [31:0] v;
  logic signed [63:0] ab;
  logic signed [63:0] t;
  logic signed [31:0] y;
  logic signed [32:0] fl;
  logic               inc;
  logic signed [32:0] r;
  logic signed [7:0]  res;
  logic               res_last;
  logic               out_valid;
  logic               load;

  // left shift with saturation
  logic        [4:0]  lsh;
  logic signed [62:0] wide;
  logic               ovf;
  // rounding right shift
  logic        [5:0]  rs;
  logic signed [32:0] ye;
  logic        [32:0] mask;
  logic        [32:0] rem;
  logic        [32:0] thr;
  // truncating divide by 2^31
  logic               adj;
  // clamps
  logic signed [32:0] c1;
  logic signed [32:0] c2;

  always_comb begin
    lsh  = shamt[5] ? 5'd0 : shamt[4:0];
    wide = $signed({{31{x[31]}}, x}) <<< lsh;
    ovf  = (wide[62:31] != {32{wide[62]}});

    adj  = t[63] && (t[30:0] != '0);

    rs   = shamt[5] ? (6'd0 - shamt) : 6'd0;
    ye   = {y[31], y};
    mask = (33'd1 << rs) - 33'd1;
    rem  = {1'b0, y} & mask;
    thr  = (mask >> 1) + {32'd0, y[31]};

    // act_min, then act_max; result always lands in int8
    c1 = (r < 33'(cfg.act_min)) ? 33'(cfg.act_min) : r;
    c2 = (c1 > 33'(cfg.act_max)) ? 33'(cfg.act_max) : c1;
    if (c2 < 33'(INT8_MIN)) begin
      c2 = 33'(INT8_MIN);
    end else if (c2 > 33'(INT8_MAX)) begin
      c2 = 33'(INT8_MAX);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (!q_stat.empty) state_next = BK_LSH;
      BK_LSH:   state_next = BK_MUL;
      BK_MUL:   state_next = BK_RND;
      BK_RND:   state_next = BK_DIV;
      BK_DIV:   state_next = BK_RSH;
      BK_RSH:   state_next = BK_OFS;
      BK_OFS:   state_next = BK_CLAMP;
      BK_CLAMP: if (!out_valid || out_ch.ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop          = 1'b0;
    load         = 1'b0;
    bk_stat.busy = 1'b1;
    case (state)
      BK_IDLE: begin
        pop          = !q_stat.empty;
        bk_stat.busy = 1'b0;
      end
      BK_CLAMP: load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          x       <= head.acc + head.bias;
          mult    <= head.multiplier;
          shamt   <= head.shift;
          last_ch <= head.last_channel;
        end
      end
      BK_LSH:  v  <= ovf ? (wide[62] ? INT32_MIN : INT32_MAX) : wide[31:0];
      BK_MUL:  ab <= v * $signed({1'b0, mult});
      BK_RND:  t  <= ab + (ab[63] ? NUDGE_NEG : NUDGE_POS);
      BK_DIV:  y  <= t[62:31] + {31'd0, adj};
      BK_RSH: begin
        fl  <= ye >>> rs;
        inc <= (rem > thr);
      end
      BK_OFS:  r  <= fl + $signed({32'd0, inc}) + 33'(cfg.output_zero_point);
      BK_CLAMP: begin
        if (load) begin
          res      <= c2[7:0];
          res_last <= last_ch;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result_value = res;
  assign out_ch.last_output  = res_last;

endmodule

`default_nettype wire

// File: rtl/core/int8_fully_connected_mac_top.sv
// Top level of the int8 fully connected MAC core: config registers and wiring.
// Depends on fcm_pkg, fcm_channels, fcm_front, fcm_queue, fcm_back and the defines header.
//
//  port        dir   kind          payload
//  ----------  ----  ------------  ---------------------------------------------------
//  in_ch       in    valid/ready   activation, weight, last_in_row, bias, multiplier,
//                                  shift, last_channel
//  out_ch      out   valid/ready   result_value, last_output
//  cfg_*       in    write only    cfg_we, cfg_index (2b), cfg_data (8b)
//
// The front takes one request and does one MAC per cycle while the queue is not full.
// A row passes through the back end as a queue pop plus seven requantize steps,
// one 32x32 multiply among them; requests stream at one per cycle while the queue
// has room, and once the queue is full the back end paces in_ch.
// Reset (rst, synchronous) clears accumulator, queue and back end, loads register defaults.
// The output register holds a stalled result; the queue decouples back end from in_ch.
`default_nettype none
`include "int8_fully_connected_mac_top_defines.svh"

module int8_fully_connected_mac_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  fcm_in_if.sink                          in_ch,
  fcm_out_if.source                       out_ch
);
  import fcm_pkg::*;

  logic signed [7:0] input_zero_point;
  clamp_cfg_t        clamp_cfg;

  logic       push;
  row_job_t   push_job;
  logic       pop;
  row_job_t   head;
  q_status_t  q_stat;
  bk_status_t bk_stat;

  // register writes must only happen while the core is idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      input_zero_point            <= 8'sd0;
      clamp_cfg.output_zero_point <= 8'sd0;
      clamp_cfg.act_min           <= INT8_MIN;
      clamp_cfg.act_max           <= INT8_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_ZP:  input_zero_point            <= cfg_data;
        REG_OUTPUT_ZP: clamp_cfg.output_zero_point <= cfg_data;
        REG_ACT_MIN:   clamp_cfg.act_min           <= cfg_data;
        REG_ACT_MAX:   clamp_cfg.act_max           <= cfg_data;
        default: ;
      endcase
    end
  end

  fcm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .input_zero_point (input_zero_point),
    .in_ch            (in_ch),
    .q_stat           (q_stat),
    .push             (push),
    .push_job         (push_job)
  );

  fcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  fcm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (clamp_cfg),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .bk_stat (bk_stat),
    .out_ch  (out_ch)
  );

  // back end never pops an empty queue
  `FCM_ASSERT_IMPL(a_pop_nonempty, clk, rst, pop, !q_stat.empty)
  // a finished row is visible in the queue on the next cycle
  `FCM_ASSERT_NEXT(a_row_queued, clk, rst, push, !q_stat.empty)
  // a pop always starts a requantize sequence
  `FCM_ASSERT_NEXT(a_pop_starts, clk, rst, pop, bk_stat.busy)

endmodule

`default_nettype wire
